// ===== src/cpfs_pkg.sv =====
`timescale 1ns / 1ps
package cpfs_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_W        = 16;
  localparam int IDX_W          = 6;
  localparam int THR_W          = 32;
  localparam int ACTIVE_W       = 7;
  localparam int CFG_IDX_W      = 1;
  localparam int DEN_SQ_W       = 50;
  localparam int QUOT_W         = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_POINTS = 1'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_DIFF, ST_MX, ST_MY, ST_MZ, ST_MS, ST_ML, ST_MH,
    ST_MD, ST_MQ, ST_DST, ST_DIV, ST_ACC, ST_DONE
  } state_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_stat_t;

endpackage

// ===== src/cpfs_in_if.sv =====
`timescale 1ns / 1ps
interface cpfs_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [5:0]  entry_index;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic [15:0] kernel_width;

  modport source (output valid, op, entry_index, coord_x, coord_y, coord_z, kernel_width,
                  input ready);
  modport sink (input valid, op, entry_index, coord_x, coord_y, coord_z, kernel_width,
                output ready);
endinterface

// ===== src/cpfs_out_if.sv =====
`timescale 1ns / 1ps
interface cpfs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] field_value;

  modport source (output valid, field_value, input ready);
  modport sink (input valid, field_value, output ready);
endinterface

// ===== src/cauchy_point_field_sum_core.sv =====
`timescale 1ns / 1ps
// Load beat: written into the table, no result.
// Query beat: result after N entries, N = min(active_points, MAX_POINTS);
// an entry runs three squares, S*S, two products and den*den through one shared 32x32
// multiplier, then a 17-bit restoring divider (den*den and divider skipped if the term drops).
// Reset (synchronous, rst_n low) clears threshold, active_points and control state;
// the table is not cleared. One item at a time; not ready until the result is in the output register.
module cauchy_point_field_sum_core #(
  parameter int MAX_POINTS = cpfs_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cpfs_in_if.sink                         in_if,
  cpfs_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [cpfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpfs_pkg::THR_W-1:0]      cfg_wdata
);
  import cpfs_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  state_t state_r, state_nxt;

  logic [63:0] mem [MAX_POINTS];
  logic [63:0] rd_r;

  logic signed [THR_W-1:0] thr_r;
  logic [ACTIVE_W-1:0]     active_r;

  logic [15:0] px_r, py_r, pz_r;
  logic [15:0] adx_r, ady_r, adz_r, s_r;
  logic [33:0] r2_r;
  logic [31:0] s2_r;
  logic [63:0] lo_r;
  logic [24:0] den_r;
  logic [15:0] term_r;
  logic [47:0] acc_r;
  logic [CW-1:0] ptr_r, cnt_r, count;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p_r;

  logic        ov_r;
  logic [31:0] out_r;

  logic        div_start;
  div_stat_t   div_stat;

  logic        accept, out_free;
  logic signed [16:0] dx, dy, dz;
  logic [63:0] prod;
  logic signed [47:0] diff;
  logic [31:0] sat;

  assign accept   = in_if.valid && in_if.ready;
  assign out_free = !ov_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign out_if.valid = ov_r;
  assign out_if.field_value = out_r;

  assign count = (32'(active_r) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(active_r);

  function automatic logic [15:0] abs17(input logic signed [16:0] v);
    logic signed [16:0] m;
    m = v[16] ? -v : v;
    return m[15:0];
  endfunction

  assign dx = $signed({rd_r[15], rd_r[15:0]})   - $signed({px_r[15], px_r});
  assign dy = $signed({rd_r[31], rd_r[31:16]})  - $signed({py_r[15], py_r});
  assign dz = $signed({rd_r[47], rd_r[47:32]})  - $signed({pz_r[15], pz_r});

  assign prod = mul_p_r + {16'd0, lo_r[63:16]};
  assign diff = $signed(acc_r) - 48'(thr_r);
  assign sat  = (diff > 48'sd2147483647)  ? 32'h7FFF_FFFF :
                (diff < -48'sd2147483648) ? 32'h8000_0000 : diff[31:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MX: begin mul_a = {16'd0, adx_r}; mul_b = {16'd0, adx_r}; end
      ST_MY: begin mul_a = {16'd0, ady_r}; mul_b = {16'd0, ady_r}; end
      ST_MZ: begin mul_a = {16'd0, adz_r}; mul_b = {16'd0, adz_r}; end
      ST_MS: begin mul_a = {16'd0, s_r};   mul_b = {16'd0, s_r};   end
      ST_ML: begin mul_a = mul_p_r[31:0];  mul_b = {16'd0, r2_r[15:0]}; end
      ST_MH: begin mul_a = s2_r;           mul_b = {14'd0, r2_r[33:16]}; end
      ST_MQ: begin mul_a = {7'd0, den_r};  mul_b = {7'd0, den_r}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (accept && in_if.op == OP_LOAD && 32'(in_if.entry_index) < MAX_POINTS) begin
      mem[AW'(in_if.entry_index)] <= {in_if.kernel_width, in_if.coord_z,
                                      in_if.coord_y, in_if.coord_x};
    end
    rd_r <= mem[ptr_r[AW-1:0]];
  end

  cpfs_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .den_sq (mul_p_r[DEN_SQ_W-1:0]),
    .stat   (div_stat)
  );

  assign div_start = (state_r == ST_DST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      thr_r    <= '0;
      active_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THRESHOLD:     thr_r    <= cfg_wdata;
          CFG_ACTIVE_POINTS: active_r <= cfg_wdata[ACTIVE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      ov_r <= 1'b1;
    end else if (out_if.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        px_r  <= in_if.coord_x;
        py_r  <= in_if.coord_y;
        pz_r  <= in_if.coord_z;
        acc_r <= '0;
        ptr_r <= '0;
        cnt_r <= count;
      end
      ST_DIFF: begin
        adx_r <= abs17(dx);
        ady_r <= abs17(dy);
        adz_r <= abs17(dz);
        s_r   <= rd_r[63:48];
      end
      ST_MY: r2_r <= {2'd0, mul_p_r[31:0]};
      ST_MZ: r2_r <= r2_r + {2'd0, mul_p_r[31:0]};
      ST_MS: r2_r <= r2_r + {2'd0, mul_p_r[31:0]};
      ST_ML: s2_r <= mul_p_r[31:0];
      ST_MH: lo_r <= mul_p_r;
      ST_MD: begin
        // drop the term when the denominator reaches 2^25
        if (prod >= 64'h1FF_0000) term_r <= '0;
        den_r <= 25'h1_0000 + prod[24:0];
      end
      ST_DIV: begin
        if (div_stat.done) begin
          term_r <= div_stat.quot[16] ? 16'hFFFF : div_stat.quot[15:0];
        end
      end
      ST_ACC: begin
        acc_r <= acc_r + {32'd0, term_r};
        ptr_r <= ptr_r + CW'(1);
      end
      ST_DONE: if (out_free) out_r <= sat;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_if.op == OP_QUERY) begin
          state_nxt = (count == '0) ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MX;
      ST_MX:    state_nxt = ST_MY;
      ST_MY:    state_nxt = ST_MZ;
      ST_MZ:    state_nxt = ST_MS;
      ST_MS:    state_nxt = ST_ML;
      ST_ML:    state_nxt = ST_MH;
      ST_MH:    state_nxt = ST_MD;
      ST_MD:    state_nxt = (prod >= 64'h1FF_0000) ? ST_ACC : ST_MQ;
      ST_MQ:    state_nxt = ST_DST;
      ST_DST:   state_nxt = ST_DIV;
      ST_DIV:   if (div_stat.done) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = (ptr_r + CW'(1) == cnt_r) ? ST_DONE : ST_FETCH;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== src/cpfs_div.sv =====
`timescale 1ns / 1ps
module cpfs_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [cpfs_pkg::DEN_SQ_W-1:0]  den_sq,
  output cpfs_pkg::div_stat_t            stat
);
  import cpfs_pkg::*;

  localparam int REM_W   = 49;
  localparam int TRIAL_W = DEN_SQ_W + QUOT_W;

  logic [DEN_SQ_W-1:0] q_r;
  logic [REM_W-1:0]    rem_r;
  logic [QUOT_W-1:0]   quot_r;
  logic [4:0]          cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [TRIAL_W-1:0]  trial;
  logic                fits;

  // 2^48 / den_sq, one quotient bit a cycle, msb first
  assign trial = {{QUOT_W{1'b0}}, q_r} << cnt_r;
  assign fits  = {{(TRIAL_W-REM_W){1'b0}}, rem_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= den_sq;
        rem_r  <= REM_W'(1) << 48;
        quot_r <= '0;
        cnt_r  <= 5'(QUOT_W - 1);
      end else if (busy_r) begin
        if (fits) begin
          rem_r  <= rem_r - trial[REM_W-1:0];
          quot_r <= quot_r | (QUOT_W'(1) << cnt_r);
        end
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  assign stat.done = done_r;
  assign stat.quot = quot_r;
endmodule
